### rtl/core/fsp_pkg.sv
// Shared types and constants for the fair share task picker.
// Used by fsp_mul, fsp_div and the top level; depends on nothing.
package fsp_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int ID_W   = 16;
  localparam int WT_W   = 16;
  localparam int RT_W   = 40;
  localparam int CT_W   = 32;
  localparam int US_W   = 20;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int POL_W  = 2;
  localparam int CIDX_W = 2;
  localparam int PROD_W = RT_W + WT_W;
  localparam int NUM_W  = US_W + WT_W;
  localparam int IN_W   = 88;

  localparam logic [US_W-1:0]  DEF_LATENCY_US = US_W'(20000);
  localparam logic [POL_W-1:0] RST_POLICY     = POL_W'(2);
  localparam logic [US_W-1:0]  RST_QUANTUM    = US_W'(10000);
  localparam logic [US_W-1:0]  RST_LATENCY    = US_W'(20000);
  localparam logic [US_W-1:0]  RST_MIN_GRAN   = US_W'(2000);
  localparam logic [RT_W-1:0]  RT_MAX         = '1;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_PICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_NOPICK = 2'd3;

  localparam logic [POL_W-1:0] POL_FCFS = 2'd0;
  localparam logic [POL_W-1:0] POL_RR   = 2'd1;

  localparam logic [CIDX_W-1:0] REG_POLICY   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_QUANTUM  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LATENCY  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_MIN_GRAN = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [WT_W-1:0] weight;
    logic [RT_W-1:0] runtime;
    logic [CT_W-1:0] created;
  } fsp_entry_t;

  localparam int ENTRY_W = $bits(fsp_entry_t);

endpackage

### rtl/core/fsp_ram.sv
// Generic single write port RAM with one registered read port.
// Stand-alone; no package needed.
module fsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/fsp_mul.sv
// Shared multiplier: runtime-wide by weight-wide, product registered.
// Depends on fsp_pkg.
module fsp_mul (
  input  logic                      clk,
  input  logic [fsp_pkg::RT_W-1:0]   a,
  input  logic [fsp_pkg::WT_W-1:0]   b,
  output logic [fsp_pkg::PROD_W-1:0] prod
);
  import fsp_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

### rtl/core/fsp_div.sv
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// Depends on fsp_pkg.
module fsp_div #(
  parameter int DEN_W = 21
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [fsp_pkg::NUM_W-1:0] num,
  input  logic [DEN_W-1:0]         den,
  output logic [fsp_pkg::NUM_W-1:0] quo,
  output logic [DEN_W-1:0]         rem,
  output logic                     done
);
  import fsp_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign sh   = {rem, quo[NUM_W-1]};
  assign diff = sh - {1'b0, dreg};
  assign ge   = sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num;
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

### rtl/core/fair_share_task_picker_unit.sv
// Top level of the fair share task picker: sequencer, task table, config.
// Depends on fsp_pkg, fsp_ram, fsp_mul and fsp_div.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tuser = op, s_tdata = task fields
//  m_*       out  m_tvalid / m_tready  m_tuser = status, m_tdata = results
//  cfg_*     in   cfg_we               cfg_idx, cfg_data
//
// Add and clear go straight to the result; report reads the picked entry,
// writes its runtime back and, for a completed task, moves each entry behind
// it up one slot. Round robin pick has the divider give the pointer modulo
// count; fair pick has the shared multiplier form two cross products per
// entry, then the divider gives the slice. One request at a time; the next
// request is taken while a result waits on m_tready. Reset clears the count,
// pointer and pending pick; the table itself needs no clearing.
module fair_share_task_picker_unit #(
  parameter int MAX_TASKS = fsp_pkg::MAX_TASKS_DEF,
  localparam int SW    = $clog2(MAX_TASKS),
  localparam int CW    = $clog2(MAX_TASKS + 1),
  localparam int OUT_W = ((fsp_pkg::ID_W + SW + fsp_pkg::US_W + CW + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // new_pid[15:0], weight[31:16], created_time[63:32], ran_us[83:64], complete[84]
  input  logic [fsp_pkg::IN_W-1:0]   s_tdata,
  // op
  input  logic [fsp_pkg::OP_W-1:0]   s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // picked_pid, picked_slot, slice_us, task_count, zero fill
  output logic [OUT_W-1:0]           m_tdata,
  // status
  output logic [fsp_pkg::ST_W-1:0]   m_tuser,
  input  logic                       cfg_we,
  input  logic [fsp_pkg::CIDX_W-1:0] cfg_idx,
  input  logic [fsp_pkg::US_W-1:0]   cfg_data
);
  import fsp_pkg::*;

  localparam int TOT_W = WT_W + CW;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_PK_RD    = 12'b0000_0000_0010,
    S_FC_FIRST = 12'b0000_0000_0100,
    S_FC_M1    = 12'b0000_0000_1000,
    S_FC_M2    = 12'b0000_0001_0000,
    S_FC_CMP   = 12'b0000_0010_0000,
    S_FS_MUL   = 12'b0000_0100_0000,
    S_FS_DIV0  = 12'b0000_1000_0000,
    S_DIV      = 12'b0001_0000_0000,
    S_RP_RD    = 12'b0010_0000_0000,
    S_SH_WR    = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  // configuration
  logic [POL_W-1:0] policy;
  logic [US_W-1:0]  quantum_us, target_latency_us, min_granularity_us;

  // control state
  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [SW-1:0]  rotate_pointer, rotate_pointer_next;
  logic [SW-1:0]  picked_index, picked_index_next;
  logic           pick_pending, pick_pending_next;
  logic           out_valid, out_valid_next;

  // working registers
  logic [OP_W-1:0]  op_r, op_r_next;
  logic [US_W-1:0]  ran, ran_next;
  logic             complete, complete_next;
  logic [CW-1:0]    scan, scan_next;
  logic [SW-1:0]    sel, sel_next;
  fsp_entry_t       best, best_next, cand, cand_next;
  logic [PROD_W-1:0] lhs, lhs_next;
  logic [TOT_W-1:0] total, total_next;
  logic [ST_W-1:0]  res_status, res_status_next;
  logic [ID_W-1:0]  res_pid, res_pid_next;
  logic [SW-1:0]    res_slot, res_slot_next;
  logic [US_W-1:0]  res_slice, res_slice_next;

  // output register
  logic [ST_W-1:0] o_status;
  logic [ID_W-1:0] o_pid;
  logic [SW-1:0]   o_slot;
  logic [US_W-1:0] o_slice;
  logic [CW-1:0]   o_count;
  logic            o_load;

  // table RAM
  logic          ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  fsp_entry_t    ram_wdata, ram_rdata;

  // shared units
  logic [RT_W-1:0]   mul_a;
  logic [WT_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [TOT_W-1:0]  div_den, div_rem;

  // request fields
  logic [ID_W-1:0] in_pid;
  logic [WT_W-1:0] in_weight;
  logic [CT_W-1:0] in_created;
  logic [US_W-1:0] in_ran;
  logic            in_complete;
  logic            accept;

  assign in_pid      = s_tdata[15:0];
  assign in_weight   = s_tdata[31:16];
  assign in_created  = s_tdata[63:32];
  assign in_ran      = s_tdata[83:64];
  assign in_complete = s_tdata[84];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tuser  = o_status;
  assign m_tdata  = OUT_W'({o_count, o_slice, o_slot, o_pid});

  fsp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fsp_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  fsp_div #(.DEN_W(TOT_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      policy             <= RST_POLICY;
      quantum_us         <= RST_QUANTUM;
      target_latency_us  <= RST_LATENCY;
      min_granularity_us <= RST_MIN_GRAN;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_POLICY:   policy             <= cfg_data[POL_W-1:0];
        REG_QUANTUM:  quantum_us         <= cfg_data;
        REG_LATENCY:  target_latency_us  <= cfg_data;
        REG_MIN_GRAN: min_granularity_us <= cfg_data;
        default:      policy             <= policy;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_FC_M1: begin
        mul_a = ram_rdata.runtime;
        mul_b = best.weight;
      end
      S_FC_M2: begin
        mul_a = best.runtime;
        mul_b = cand.weight;
      end
      S_FS_MUL: begin
        mul_a = RT_W'(target_latency_us == '0 ? DEF_LATENCY_US : target_latency_us);
        mul_b = best.weight;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    logic             take;
    logic [RT_W:0]    rt_sum;
    logic [CW-1:0]    newc;
    logic [SW-1:0]    rot_rm;
    logic [CW-1:0]    scan_inc;
    logic [NUM_W-1:0] min_ext;

    state_next          = state;
    count_next          = count;
    rotate_pointer_next = rotate_pointer;
    picked_index_next   = picked_index;
    pick_pending_next   = pick_pending;
    out_valid_next      = out_valid;
    op_r_next           = op_r;
    ran_next            = ran;
    complete_next       = complete;
    scan_next           = scan;
    sel_next            = sel;
    best_next           = best;
    cand_next           = cand;
    lhs_next            = lhs;
    total_next          = total;
    res_status_next     = res_status;
    res_pid_next        = res_pid;
    res_slot_next       = res_slot;
    res_slice_next      = res_slice;
    o_load              = 1'b0;
    ram_we              = 1'b0;
    ram_waddr           = '0;
    ram_wdata           = ram_rdata;
    ram_raddr           = '0;
    div_start           = 1'b0;
    div_num             = '0;
    div_den             = '0;

    take = (lhs < prod) ||
           ((lhs == prod) && ((cand.weight > best.weight) ||
                              ((cand.weight == best.weight) &&
                               (cand.created < best.created))));
    rt_sum   = {1'b0, ram_rdata.runtime} + (RT_W + 1)'(ran);
    newc     = count - 1'b1;
    rot_rm   = (CW'(picked_index) == newc) ? '0 : picked_index;
    scan_inc = scan + 1'b1;
    min_ext  = NUM_W'(min_granularity_us);

    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_r_next       = s_tuser;
          ran_next        = in_ran;
          complete_next   = in_complete;
          res_status_next = ST_OK;
          res_pid_next    = '0;
          res_slot_next   = '0;
          res_slice_next  = '0;
          state_next      = S_DONE;
          unique case (s_tuser)
            OP_ADD: begin
              if (count == CW'(MAX_TASKS)) begin
                res_status_next = ST_FULL;
              end else begin
                ram_we            = 1'b1;
                ram_waddr         = count[SW-1:0];
                ram_wdata.id      = in_pid;
                ram_wdata.weight  = (in_weight == '0) ? WT_W'(1) : in_weight;
                ram_wdata.runtime = '0;
                ram_wdata.created = in_created;
                count_next        = count + 1'b1;
              end
            end
            OP_PICK: begin
              if (count == '0) begin
                res_status_next   = ST_EMPTY;
                pick_pending_next = 1'b0;
              end else if (policy == POL_FCFS) begin
                sel_next   = '0;
                ram_raddr  = '0;
                state_next = S_PK_RD;
              end else if (policy == POL_RR) begin
                // pointer may lag a shrunken table: take it modulo count
                div_start  = 1'b1;
                div_num    = NUM_W'(rotate_pointer);
                div_den    = TOT_W'(count);
                state_next = S_DIV;
              end else begin
                ram_raddr  = '0;
                sel_next   = '0;
                scan_next  = CW'(1);
                state_next = S_FC_FIRST;
              end
            end
            OP_REPORT: begin
              if (!pick_pending || CW'(picked_index) >= count) begin
                res_status_next = ST_NOPICK;
              end else begin
                ram_raddr  = picked_index;
                state_next = S_RP_RD;
              end
            end
            OP_CLEAR: begin
              count_next          = '0;
              rotate_pointer_next = '0;
              picked_index_next   = '0;
              pick_pending_next   = 1'b0;
            end
            default: state_next = S_DONE;
          endcase
        end
      end

      S_PK_RD: begin
        res_pid_next      = ram_rdata.id;
        res_slot_next     = sel;
        res_slice_next    = quantum_us;
        picked_index_next = sel;
        pick_pending_next = 1'b1;
        state_next        = S_DONE;
      end

      S_FC_FIRST: begin
        best_next  = ram_rdata;
        total_next = TOT_W'(ram_rdata.weight);
        if (scan >= count) begin
          state_next = S_FS_MUL;
        end else begin
          ram_raddr  = scan[SW-1:0];
          state_next = S_FC_M1;
        end
      end

      S_FC_M1: begin
        cand_next  = ram_rdata;
        state_next = S_FC_M2;
      end

      S_FC_M2: begin
        lhs_next   = prod;
        state_next = S_FC_CMP;
      end

      S_FC_CMP: begin
        if (take) begin
          best_next = cand;
          sel_next  = scan[SW-1:0];
        end
        total_next = total + TOT_W'(cand.weight);
        scan_next  = scan_inc;
        if (scan_inc >= count) begin
          state_next = S_FS_MUL;
        end else begin
          ram_raddr  = scan_inc[SW-1:0];
          state_next = S_FC_M1;
        end
      end

      S_FS_MUL: begin
        state_next = S_FS_DIV0;
      end

      S_FS_DIV0: begin
        div_start  = 1'b1;
        div_num    = prod[NUM_W-1:0];
        div_den    = total;
        state_next = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          if (policy == POL_RR) begin
            sel_next   = div_rem[SW-1:0];
            ram_raddr  = div_rem[SW-1:0];
            state_next = S_PK_RD;
          end else begin
            res_pid_next      = best.id;
            res_slot_next     = sel;
            res_slice_next    = (div_quo < min_ext) ? min_granularity_us
                                                    : div_quo[US_W-1:0];
            picked_index_next = sel;
            pick_pending_next = 1'b1;
            state_next        = S_DONE;
          end
        end
      end

      S_RP_RD: begin
        ram_we            = 1'b1;
        ram_waddr         = picked_index;
        ram_wdata.runtime = rt_sum[RT_W] ? RT_MAX : rt_sum[RT_W-1:0];
        res_pid_next      = ram_rdata.id;
        res_slot_next     = picked_index;
        pick_pending_next = 1'b0;
        state_next        = S_DONE;
        scan_next         = CW'(picked_index) + 1'b1;
        if (complete) begin
          if (CW'(picked_index) + 1'b1 < count) begin
            ram_raddr  = picked_index + 1'b1;
            state_next = S_SH_WR;
          end else begin
            count_next = newc;
            if (policy == POL_RR) begin
              rotate_pointer_next = rot_rm;
            end
          end
        end else if (policy == POL_RR) begin
          rotate_pointer_next = (CW'(picked_index) + 1'b1 == count) ? '0
                                : picked_index + 1'b1;
        end
      end

      S_SH_WR: begin
        // move entry scan down one slot, fetch the next behind it
        ram_we    = 1'b1;
        ram_waddr = scan[SW-1:0] - 1'b1;
        ram_wdata = ram_rdata;
        scan_next = scan_inc;
        if (scan_inc < count) begin
          ram_raddr = scan_inc[SW-1:0];
        end else begin
          count_next = newc;
          if (policy == POL_RR) begin
            rotate_pointer_next = rot_rm;
          end
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || m_tready) begin
          o_load         = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      rotate_pointer <= '0;
      picked_index   <= '0;
      pick_pending   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      count          <= count_next;
      rotate_pointer <= rotate_pointer_next;
      picked_index   <= picked_index_next;
      pick_pending   <= pick_pending_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_r_next;
    ran        <= ran_next;
    complete   <= complete_next;
    scan       <= scan_next;
    sel        <= sel_next;
    best       <= best_next;
    cand       <= cand_next;
    lhs        <= lhs_next;
    total      <= total_next;
    res_status <= res_status_next;
    res_pid    <= res_pid_next;
    res_slot   <= res_slot_next;
    res_slice  <= res_slice_next;
    if (o_load) begin
      o_status <= res_status;
      o_pid    <= res_pid;
      o_slot   <= res_slot;
      o_slice  <= (op_r == OP_PICK) ? res_slice : '0;
      o_count  <= count;
    end
  end

endmodule
